// ----- rtl/lcrf_pkg.sv -----
// Package for the longest column run finder: default sizes, the width of the
// column-count register and the control bundle broadcast to every column cell.
// No dependencies.
`default_nettype none

package lcrf_pkg;

    localparam int DEF_MAX_COLUMNS = 64;
    localparam int DEF_MAX_ROWS    = 4096;
    localparam int DEF_VALUE_BITS  = 16;

    // Width of the columns_in_use configuration register.
    localparam int CFG_BITS = 7;

    // Control broadcast from the top level to every column cell.
    typedef struct packed {
        logic accept;     // an element request is taken this cycle
        logic restart;    // the token returns to column 0 after this request
        logic first_row;  // this request lies in the first row of the matrix
        logic advance;    // the best-column stage takes its next entry
    } lcrf_cell_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/lcrf_element_if.sv -----
// Element channel: valid/ready handshake carrying one matrix element per request.
// Depends on lcrf_pkg for the default value width.
`default_nettype none

interface lcrf_element_if
    import lcrf_pkg::*;
#(
    parameter int VALUE_BITS = DEF_VALUE_BITS
) ();

    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] element_value;
    logic                         last_element;

    modport source (
        output valid,
        input  ready,
        output element_value,
        output last_element
    );

    modport sink (
        input  valid,
        output ready,
        input  element_value,
        input  last_element
    );

endinterface

`default_nettype wire

// ----- rtl/lcrf_result_if.sv -----
// Result channel: valid/ready handshake carrying the best column and its run length.
// Depends on lcrf_pkg for the default sizes.
`default_nettype none

interface lcrf_result_if
    import lcrf_pkg::*;
#(
    parameter int COLUMN_BITS = $clog2(DEF_MAX_COLUMNS),
    parameter int LENGTH_BITS = $clog2(DEF_MAX_ROWS + 1)
) ();

    logic                   valid;
    logic                   ready;
    logic [COLUMN_BITS-1:0] best_column;
    logic [LENGTH_BITS-1:0] best_length;

    modport source (
        output valid,
        input  ready,
        output best_column,
        output best_length
    );

    modport sink (
        input  valid,
        output ready,
        input  best_column,
        input  best_length
    );

endinterface

`default_nettype wire

// ----- rtl/lcrf_cell.sv -----
// One column cell: holds the last value, current run and longest run of its column
// and passes the column token to its neighbour. Depends on lcrf_pkg.
`default_nettype none

module lcrf_cell
    import lcrf_pkg::*;
#(
    parameter int VALUE_BITS  = DEF_VALUE_BITS,
    parameter int LENGTH_BITS = $clog2(DEF_MAX_ROWS + 1),
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter bit IS_HEAD     = 1'b0
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire lcrf_cell_ctrl_t        ctrl,
    input  wire logic [VALUE_BITS-1:0]  value,
    input  wire logic                   token_in,
    output logic                        token_out,
    output logic [LENGTH_BITS-1:0]      longest_out
);

    localparam logic [LENGTH_BITS-1:0] RUN_LIMIT = LENGTH_BITS'(MAX_ROWS);
    localparam logic [LENGTH_BITS-1:0] RUN_ONE   = LENGTH_BITS'(1);

    logic                   token_reg,   token_next;
    logic                   hit_reg,     hit_next;
    logic [VALUE_BITS-1:0]  prev_reg;
    logic [LENGTH_BITS-1:0] run_reg,     run_next;
    logic [LENGTH_BITS-1:0] longest_reg, longest_next;
    logic                   take;

    assign take = ctrl.accept & token_reg;

    always_comb
    begin
        if (ctrl.first_row)
        begin
            run_next     = RUN_ONE;
            longest_next = RUN_ONE;
        end
        else
        begin
            if (prev_reg == value)
            begin
                run_next = (run_reg < RUN_LIMIT) ? run_reg + RUN_ONE : run_reg;
            end
            else
            begin
                run_next = RUN_ONE;
            end
            longest_next = (run_next > longest_reg) ? run_next : longest_reg;
        end
    end

    always_comb
    begin
        token_next = token_reg;
        if (ctrl.accept)
        begin
            token_next = ctrl.restart ? IS_HEAD : token_in;
        end
        hit_next = ctrl.advance ? take : hit_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_reg <= IS_HEAD;
            hit_reg   <= 1'b0;
        end
        else
        begin
            token_reg <= token_next;
            hit_reg   <= hit_next;
        end
    end

    // Column contents need no reset: they are written by the first row.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            prev_reg    <= value;
            run_reg     <= run_next;
            longest_reg <= longest_next;
        end
    end

    assign token_out   = token_reg;
    assign longest_out = hit_reg ? longest_reg : '0;

endmodule

`default_nettype wire

// ----- rtl/longest_column_run_finder_unit.sv -----
// Top level of the longest column run finder: the column cell chain, position and
// row tracking, the best-column stage and the result register.
// Depends on lcrf_pkg, lcrf_element_if, lcrf_result_if and lcrf_cell.
`default_nettype none

// The block takes a matrix of signed elements in row-major order, one element
// per request, with columns_in_use elements to a row (0 acts as 1, and a count
// above MAX_COLUMNS acts as MAX_COLUMNS). It follows, for every column, the run
// of equal vertically adjacent values and the longest such run, and keeps the
// column with the longest run, the lowest index winning a tie. A request marked
// last produces one result request carrying that column and its run length
// (saturating at MAX_ROWS); the next element then opens a new matrix at column 0.
// Each column lives in a cell of a chain, and a one-hot token handed from cell
// to cell marks the column that the next element belongs to, so one element is
// taken in every clock cycle unless the input stalls. A result passes through the
// staging register into an output register and waits there; the input stalls only
// when a further last element meets a result that has not yet been taken.
// columns_in_use should be rewritten only between matrices, while no element is
// in flight; a new count applies from the next element taken.
module longest_column_run_finder_unit
    import lcrf_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int VALUE_BITS  = DEF_VALUE_BITS
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_write_enable,
    input  wire logic [CFG_BITS-1:0] cfg_write_data,
    lcrf_element_if.sink             element,
    lcrf_result_if.source            result
);

    localparam int POS_BITS    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int LENGTH_BITS = (MAX_ROWS > 1) ? $clog2(MAX_ROWS + 1) : 1;
    localparam int LIMIT_BITS  = $clog2(MAX_COLUMNS + 1);
    localparam int CNT_BITS    = (LIMIT_BITS > CFG_BITS) ? LIMIT_BITS : CFG_BITS;

    localparam logic [CNT_BITS-1:0] COL_LIMIT = CNT_BITS'(MAX_COLUMNS);
    localparam logic [CNT_BITS-1:0] CNT_ONE   = CNT_BITS'(1);

    // Configuration register.
    logic [CFG_BITS-1:0] columns_in_use_reg;

    // Element side: position within the row and first-row flag.
    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic                first_row_reg, first_row_next;

    // Stage between the cells and the best-column update.
    logic                s1_valid_reg, s1_valid_next;
    logic                s1_last_reg;
    logic [POS_BITS-1:0] s1_col_reg;

    // Running best of the current matrix.
    logic [POS_BITS-1:0]    best_col_reg,    best_col_next;
    logic [LENGTH_BITS-1:0] best_len_reg,    best_len_next;

    // Result register.
    logic                   out_valid_reg,   out_valid_next;
    logic [POS_BITS-1:0]    out_col_reg;
    logic [LENGTH_BITS-1:0] out_len_reg;

    logic [CNT_BITS-1:0]    cols_active;
    logic                   accept;
    logic                   wrap;
    logic                   s2_go;
    logic                   s2_take;
    logic                   better;
    logic [POS_BITS-1:0]    upd_col;
    logic [LENGTH_BITS-1:0] upd_len;
    logic [LENGTH_BITS-1:0] sel_longest;

    lcrf_cell_ctrl_t        cell_ctrl;
    logic [MAX_COLUMNS-1:0] token;
    logic [LENGTH_BITS-1:0] cell_longest [MAX_COLUMNS];

    // Effective column count after clamping the register to its legal range.
    always_comb
    begin
        if (columns_in_use_reg == '0)
        begin
            cols_active = CNT_ONE;
        end
        else if (CNT_BITS'(columns_in_use_reg) > COL_LIMIT)
        begin
            cols_active = COL_LIMIT;
        end
        else
        begin
            cols_active = CNT_BITS'(columns_in_use_reg);
        end
    end

    // The best-column stage can move unless it holds a last element whose
    // result would find the output register still occupied.
    assign s2_go   = !s1_valid_reg || !s1_last_reg || !out_valid_reg || result.ready;
    assign s2_take = s1_valid_reg && s2_go;

    assign element.ready = s2_go;
    assign accept        = element.valid && s2_go;

    // The row ends once the next position reaches the column count.
    assign wrap = (CNT_BITS'(pos_reg) + CNT_ONE) >= cols_active;

    always_comb
    begin
        pos_next       = pos_reg;
        first_row_next = first_row_reg;
        if (accept)
        begin
            if (wrap || element.last_element)
            begin
                pos_next = '0;
            end
            else
            begin
                pos_next = pos_reg + POS_BITS'(1);
            end
            if (element.last_element)
            begin
                first_row_next = 1'b1;
            end
            else if (wrap)
            begin
                first_row_next = 1'b0;
            end
        end
    end

    assign cell_ctrl.accept    = accept;
    assign cell_ctrl.restart   = wrap || element.last_element;
    assign cell_ctrl.first_row = first_row_reg;
    assign cell_ctrl.advance   = s2_go;

    // The column cells; the token enters the chain at column 0.
    for (genvar i = 0; i < MAX_COLUMNS; i++)
    begin : g_cell
        logic token_from_left;

        if (i == 0)
        begin : g_head
            assign token_from_left = 1'b0;
        end
        else
        begin : g_body
            assign token_from_left = token[i-1];
        end

        lcrf_cell #(
            .VALUE_BITS  (VALUE_BITS),
            .LENGTH_BITS (LENGTH_BITS),
            .MAX_ROWS    (MAX_ROWS),
            .IS_HEAD     (i == 0)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (cell_ctrl),
            .value       (element.element_value),
            .token_in    (token_from_left),
            .token_out   (token[i]),
            .longest_out (cell_longest[i])
        );
    end

    // Only the cell that took the staged element drives a non-zero longest run.
    always_comb
    begin
        sel_longest = '0;
        for (int i = 0; i < MAX_COLUMNS; i++)
        begin
            sel_longest = sel_longest | cell_longest[i];
        end
    end

    // A longer run wins; an equal run wins only from a lower column.
    assign better = (sel_longest > best_len_reg) ||
                    ((sel_longest == best_len_reg) && (s1_col_reg < best_col_reg));
    assign upd_col = better ? s1_col_reg  : best_col_reg;
    assign upd_len = better ? sel_longest : best_len_reg;

    always_comb
    begin
        s1_valid_next  = s2_go ? accept : s1_valid_reg;
        best_col_next  = best_col_reg;
        best_len_next  = best_len_reg;
        out_valid_next = out_valid_reg && !result.ready;
        if (s2_take)
        begin
            if (s1_last_reg)
            begin
                best_col_next  = '0;
                best_len_next  = '0;
                out_valid_next = 1'b1;
            end
            else
            begin
                best_col_next = upd_col;
                best_len_next = upd_len;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_in_use_reg <= CFG_BITS'(1);
            pos_reg            <= '0;
            first_row_reg      <= 1'b1;
            s1_valid_reg       <= 1'b0;
            best_col_reg       <= '0;
            best_len_reg       <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write_enable)
            begin
                columns_in_use_reg <= cfg_write_data;
            end
            pos_reg       <= pos_next;
            first_row_reg <= first_row_next;
            s1_valid_reg  <= s1_valid_next;
            best_col_reg  <= best_col_next;
            best_len_reg  <= best_len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_last_reg <= element.last_element;
            s1_col_reg  <= pos_reg;
        end
        if (s2_take && s1_last_reg)
        begin
            out_col_reg <= upd_col;
            out_len_reg <= upd_len;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.best_column = out_col_reg;
    assign result.best_length = out_len_reg;

    // Exactly one cell holds the column token at all times.
    a_token_onehot : assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(token))
        else $error("column token is not one-hot");

    // A result appears only after a staged last element has been taken.
    a_result_source : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s2_take && s1_last_reg))
        else $error("result raised without a last element");

    // A last element opens a new matrix at column 0 in the first row.
    a_matrix_restart : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && element.last_element) |=> (pos_reg == '0) && first_row_reg && token[0])
        else $error("new matrix does not start at column 0");

endmodule

`default_nettype wire
